/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/tbqx_pkg.sv */
// Package for the two-way biquad crossover: field widths, register indexes
// and coefficient reset values. No dependencies.
package tbqx_pkg;

  // Field and datapath widths.
  localparam int RAW_W      = 12;
  localparam int X_W        = 10;
  localparam int DUTY_W     = 10;
  localparam int COEF_W     = 32;
  localparam int HIST_W     = 12;
  localparam int PROD_W     = COEF_W + HIST_W;
  localparam int ACC_W      = 48;
  localparam int SAT_W      = 14;
  localparam int DUTY_CMP_W = 18;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Defaults of the top level parameters.
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int DUTY_MAX_DEF       = 1023;

  // Configuration register indexes.
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_B0   = 3'd0,
    REG_HIGH_B1   = 3'd1,
    REG_HIGH_B2   = 3'd2,
    REG_LOW_B0    = 3'd3,
    REG_LOW_B1    = 3'd4,
    REG_LOW_B2    = 3'd5,
    REG_FB_FIRST  = 3'd6,
    REG_FB_SECOND = 3'd7
  } reg_idx_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Coefficient reset values, signed Q4.28 (32 bits, sign included).
  localparam coef_t RST_HIGH_B0   = 32'sd259471701;
  localparam coef_t RST_HIGH_B1   = -32'sd527823798;
  localparam coef_t RST_HIGH_B2   = 32'sd263911899;
  localparam coef_t RST_LOW_B0    = 32'sd41680;
  localparam coef_t RST_LOW_B1    = 32'sd83359;
  localparam coef_t RST_LOW_B2    = 32'sd41680;
  localparam coef_t RST_FB_FIRST  = 32'sd527740438;
  localparam coef_t RST_FB_SECOND = -32'sd259471701;

endpackage

/* rtl/core/two_way_biquad_crossover.sv */
// Two-way biquad crossover: top level with configuration registers,
// input register, filter datapath and result register. Uses tbqx_pkg.
//
// The block takes one 12-bit converter sample per input beat, drops its two
// low bits and runs two second-order direct-form-I IIR sections on the
// 10-bit value: a high-pass (treble) and a low-pass (bass). Each section has
// its own three feedforward coefficients; the two feedback coefficients are
// shared. Coefficients are signed fixed point with COEF_FRAC_BITS fraction
// bits and are written through the configuration channel (index 0..7:
// high_b0, high_b1, high_b2, low_b0, low_b1, low_b2, fb_first, fb_second);
// the user must write them only while the block is idle, and the block does
// not enforce it. Each filter output is divided down toward zero, saturated
// to -2048..2047 for the feedback history, and saturated to 0..DUTY_MAX for
// the PWM duty value in the output beat. One output beat follows every input
// beat. The block accepts one beat per clock cycle while the sink does not
// stall. A beat goes through the input register, then through the whole
// filter step (ten 32x12 multiplies, a five-term sum, scaling, saturation)
// with no register inside into the result register, since the output
// history loop needs each sample to see the outputs of the one before. A
// full input register still takes a new beat in the same cycle as its item
// moves on, and the result register holds its beat while the sink stalls.
module two_way_biquad_crossover
  import tbqx_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int DUTY_MAX       = DUTY_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream. tdata: raw_sample [11:0], zero [15:12].
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Output stream. tdata: treble_duty [9:0], bass_duty [19:10], zero [23:20].
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]      cfg_data
);

  // Rounding offset that turns an arithmetic right shift into a
  // truncation toward zero for negative sums.
  localparam logic signed [ACC_W-1:0] TRUNC_ADD =
    {{(ACC_W-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
  localparam logic signed [ACC_W-1:0] Q_POS_CAP = ACC_W'(4096);
  localparam logic signed [ACC_W-1:0] Q_NEG_CAP = -ACC_W'(4096);
  localparam logic signed [SAT_W-1:0] HIST_HI = SAT_W'(2047);
  localparam logic signed [SAT_W-1:0] HIST_LO = -SAT_W'(2048);
  localparam logic signed [DUTY_CMP_W-1:0] DUTY_MAX_S = DUTY_CMP_W'(DUTY_MAX);

  // Coefficient registers.
  coef_t high_b0, high_b1, high_b2;
  coef_t low_b0, low_b1, low_b2;
  coef_t fb_first, fb_second;

  // Input register.
  logic           in_valid;
  logic [X_W-1:0] in_x;

  // Filter history.
  logic [X_W-1:0]           prev_in_one, prev_in_two;
  logic signed [HIST_W-1:0] treble_prev_one, treble_prev_two;
  logic signed [HIST_W-1:0] bass_prev_one, bass_prev_two;

  // Result register.
  logic              out_valid;
  logic [DUTY_W-1:0] treble_duty, bass_duty;

  logic advance;
  logic signed [ACC_W-1:0] acc_hi, acc_lo;
  logic signed [SAT_W-1:0] yh, yl;
  logic signed [HIST_W-1:0] treble_hist_next, bass_hist_next;
  logic [DUTY_W-1:0] treble_duty_next, bass_duty_next;

  // The input register moves on whenever the result register is empty or
  // is being emptied in this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);
  assign cfg_ready     = !rst;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2*DUTY_W){1'b0}}, bass_duty, treble_duty};

  // One section's sum of five products, exact in ACC_W bits.
  function automatic logic signed [ACC_W-1:0] section_sum(
    input coef_t b0, input coef_t b1, input coef_t b2,
    input coef_t f1, input coef_t f2,
    input logic [X_W-1:0] x0, input logic [X_W-1:0] x1,
    input logic [X_W-1:0] x2,
    input logic signed [HIST_W-1:0] y1, input logic signed [HIST_W-1:0] y2
  );
    logic signed [HIST_W-1:0] sx0, sx1, sx2;
    logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]  sum;
    sx0 = signed'({{(HIST_W-X_W){1'b0}}, x0});
    sx1 = signed'({{(HIST_W-X_W){1'b0}}, x1});
    sx2 = signed'({{(HIST_W-X_W){1'b0}}, x2});
    p0  = b0 * sx0;
    p1  = b1 * sx1;
    p2  = b2 * sx2;
    p3  = f1 * y1;
    p4  = f2 * y2;
    sum = p0 + p1 + p2 + p3 + p4;
    return sum;
  endfunction

  // Division by 2^COEF_FRAC_BITS toward zero, magnitude capped at 4096.
  function automatic logic signed [SAT_W-1:0] scale_down(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] adj, q;
    adj = acc[ACC_W-1] ? (acc + TRUNC_ADD) : acc;
    q   = adj >>> COEF_FRAC_BITS;
    if (q > Q_POS_CAP) begin
      return SAT_W'(4096);
    end else if (q < Q_NEG_CAP) begin
      return -SAT_W'(4096);
    end else begin
      return q[SAT_W-1:0];
    end
  endfunction

  function automatic logic signed [HIST_W-1:0] clamp_hist(
    input logic signed [SAT_W-1:0] y
  );
    if (y > HIST_HI) begin
      return HIST_HI[HIST_W-1:0];
    end else if (y < HIST_LO) begin
      return HIST_LO[HIST_W-1:0];
    end else begin
      return y[HIST_W-1:0];
    end
  endfunction

  function automatic logic [DUTY_W-1:0] to_duty(input logic signed [SAT_W-1:0] y);
    logic signed [DUTY_CMP_W-1:0] yw;
    yw = DUTY_CMP_W'(y);
    if (y[SAT_W-1]) begin
      return '0;
    end else if (yw > DUTY_MAX_S) begin
      return DUTY_MAX_S[DUTY_W-1:0];
    end else begin
      return y[DUTY_W-1:0];
    end
  endfunction

  always_comb begin
    acc_hi = section_sum(high_b0, high_b1, high_b2, fb_first, fb_second,
                         in_x, prev_in_one, prev_in_two,
                         treble_prev_one, treble_prev_two);
    acc_lo = section_sum(low_b0, low_b1, low_b2, fb_first, fb_second,
                         in_x, prev_in_one, prev_in_two,
                         bass_prev_one, bass_prev_two);
    yh = scale_down(acc_hi);
    yl = scale_down(acc_lo);
    treble_hist_next = clamp_hist(yh);
    bass_hist_next   = clamp_hist(yl);
    treble_duty_next = to_duty(yh);
    bass_duty_next   = to_duty(yl);
  end

  // Configuration registers. Write only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      high_b0   <= RST_HIGH_B0;
      high_b1   <= RST_HIGH_B1;
      high_b2   <= RST_HIGH_B2;
      low_b0    <= RST_LOW_B0;
      low_b1    <= RST_LOW_B1;
      low_b2    <= RST_LOW_B2;
      fb_first  <= RST_FB_FIRST;
      fb_second <= RST_FB_SECOND;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_HIGH_B0:   high_b0   <= cfg_data;
        REG_HIGH_B1:   high_b1   <= cfg_data;
        REG_HIGH_B2:   high_b2   <= cfg_data;
        REG_LOW_B0:    low_b0    <= cfg_data;
        REG_LOW_B1:    low_b1    <= cfg_data;
        REG_LOW_B2:    low_b2    <= cfg_data;
        REG_FB_FIRST:  fb_first  <= cfg_data;
        REG_FB_SECOND: fb_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: keeps only the upper ten bits of the sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_x <= s_axis_tdata[RAW_W-1:RAW_W-X_W];
    end
  end

  // History shifts when an item moves into the result register, so the
  // next item in the input register sees it in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_in_one     <= '0;
      prev_in_two     <= '0;
      treble_prev_one <= '0;
      treble_prev_two <= '0;
      bass_prev_one   <= '0;
      bass_prev_two   <= '0;
    end else if (advance) begin
      prev_in_two     <= prev_in_one;
      prev_in_one     <= in_x;
      treble_prev_two <= treble_prev_one;
      treble_prev_one <= treble_hist_next;
      bass_prev_two   <= bass_prev_one;
      bass_prev_one   <= bass_hist_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      treble_duty <= treble_duty_next;
      bass_duty   <= bass_duty_next;
    end
  end

endmodule

/* rtl/core/tbqx_checker.sv */
// Port-level checker for the two-way biquad crossover, bound to the top level.
// Depends on tbqx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbqx_checker
  import tbqx_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled output beat stays valid and keeps its data.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // From empty, a new result follows its input beat through both registers.
  `ASSERT_IMPLIES(a_out_from_input, clk, rst, $rose(m_axis_tvalid), $past(in_beat, 2))

  // A free downstream side always lets a new input beat in.
  `ASSERT_IMPLIES(a_ready_flow, clk, rst, m_axis_tready, s_axis_tready)

endmodule

bind two_way_biquad_crossover tbqx_checker u_tbqx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
